[rtl/sorted_priority_queue_top_assert.svh]
// Assertion macros shared by the queue's RTL modules.
// Both expect clk_i in scope; SPQ_ASSERT also expects rst_ni.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Checked while out of reset.
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spq assertion failed");

// Checked at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("spq assertion failed");

`endif

[rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP_MIN = 2'd1,
    CMD_POP_MAX = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the request
    logic exec;  // commit the operation and register the result
  } spq_cmd_t;

endpackage

`default_nettype wire

[rtl/spq_ctrl.sv]
`default_nettype none

module spq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output spq_pkg::spq_cmd_t  cmd_o,
  output logic               result_valid_o
);
  import spq_pkg::*;

  state_e state_q, state_d;
  logic   result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= cmd_o.exec;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;

  `include "sorted_priority_queue_top_assert.svh"

  // an accepted request always runs its execute cycle next
  `SPQ_ASSERT(a_accept_execs, (start && !busy) |=> (state_q == S_EXEC))
  // exactly one result per execute cycle, strobed in the cycle after it
  `SPQ_ASSERT(a_exec_strobes, (state_q == S_EXEC) |=> (result_valid_q && !busy))
  // no strobe without a preceding execute cycle
  `SPQ_ASSERT(a_strobe_source, result_valid_q |-> ($past(state_q) == S_EXEC))
  // load and commit never in the same cycle
  `SPQ_ASSERT_ALWAYS(a_cmd_excl, !(cmd_o.load && cmd_o.exec))

endmodule

`default_nettype wire

[rtl/spq_datapath.sv]
`default_nettype none

module spq_datapath #(
  parameter int unsigned CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire spq_pkg::spq_cmd_t                    cmd_i,
  input  wire logic        [spq_pkg::CMD_W-1:0]     command_i,
  input  wire logic signed [spq_pkg::KEY_W-1:0]     key_i,
  output logic signed      [spq_pkg::KEY_W-1:0]     value_o,
  output logic             [spq_pkg::STATUS_W-1:0]  status_o,
  output logic             [spq_pkg::OCC_W-1:0]     occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  // Request registers
  cmd_e                    cmd_q;
  logic signed [KEY_W-1:0] key_q;

  // Storage cells, ascending from index 0
  logic signed [KEY_W-1:0] cells_q [CAPACITY];
  logic signed [KEY_W-1:0] cells_d [CAPACITY];
  logic signed [KEY_W-1:0] ins_cells [CAPACITY];
  logic signed [KEY_W-1:0] shl_cells [CAPACITY];
  logic        [CAPACITY-1:0] le;

  logic [CW-1:0]           count_q, count_d;
  logic signed [KEY_W-1:0] value_q, value_d;
  status_e                 status_q, status_d;

  logic          empty, full;
  logic [CW-1:0] last_cnt;
  logic [IW-1:0] last_idx;
  logic [CW+OCC_W-1:0] count_ext;

  assign empty    = (count_q == '0);
  assign full     = (count_q == CAP_CNT);
  assign last_cnt = count_q - CW'(1);
  assign last_idx = last_cnt[IW-1:0];

  // Per-cell compare and shift: le is a prefix over the occupied cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    assign le[i] = (IDX < count_q) && (cells_q[i] <= key_q);
    if (i == 0) begin : g_first
      assign ins_cells[i] = le[i] ? cells_q[i] : key_q;
    end else begin : g_rest
      assign ins_cells[i] = le[i]   ? cells_q[i] :
                            le[i-1] ? key_q      : cells_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign shl_cells[i] = cells_q[i];
    end else begin : g_inner
      assign shl_cells[i] = cells_q[i+1];
    end
  end

  always_comb begin
    cells_d  = cells_q;
    count_d  = count_q;
    value_d  = '0;
    status_d = ST_OK;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cells_d = ins_cells;
          count_d = count_q + CW'(1);
        end
      end
      CMD_POP_MIN: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          value_d = cells_q[0];
          cells_d = shl_cells;
          count_d = last_cnt;
        end
      end
      CMD_POP_MAX: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          value_d = cells_q[last_idx];
          count_d = last_cnt;
        end
      end
      default: begin
        // unused code: no change, ok status
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_e'(command_i);
      key_q <= key_i;
    end
    if (cmd_i.exec) begin
      cells_q  <= cells_d;
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign count_ext   = {{OCC_W{1'b0}}, count_q};
  assign value_o     = value_q;
  assign status_o    = status_q;
  assign occupancy_o = count_ext[OCC_W-1:0];

  `include "sorted_priority_queue_top_assert.svh"

  // fill count never passes capacity
  `SPQ_ASSERT(a_count_bound, count_q <= CAP_CNT)

endmodule

`default_nettype wire

[rtl/sorted_priority_queue_top.sv]
`default_nettype none

// Sorted priority queue for signed 32-bit keys, up to CAPACITY entries.
// Pulse start with command_i/key_i while busy is low; the request is taken
// on that edge. Insert (command 0) places the key after all stored keys
// less than or equal to it, so equal keys leave pop-min in arrival
// order; pop-min (1) and pop-max (2) remove and return the smallest or
// largest key; code 3 does nothing and reports ok. Every request gives
// exactly one result, shown on value_o/status_o/occupancy_o for a single
// cycle with result_valid_o high, registered at the end of the execute
// step. There is no backpressure on the result side: the receiver must
// take it in that cycle. Status is ok, empty (pop on an empty queue,
// value 0) or full (insert at capacity, key dropped). occupancy_o is the
// count after the request, modulo 32. A request is captured, then executed:
// for an insert, every storage cell compares its key against the new one
// in parallel and the row shifts at once; busy holds off the next request.
// A new request may be accepted in the same cycle its predecessor's
// result is on the outputs. No clearing pass is needed after reset.
module sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request side
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [spq_pkg::CMD_W-1:0]    command_i,
  input  wire logic signed [spq_pkg::KEY_W-1:0]    key_i,
  // result side
  output logic                                     result_valid_o,
  output logic signed      [spq_pkg::KEY_W-1:0]    value_o,
  output logic             [spq_pkg::STATUS_W-1:0] status_o,
  output logic             [spq_pkg::OCC_W-1:0]    occupancy_o
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  // Two-state sequencer: capture, then execute.
  spq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  // Row of key cells with per-cell compare and the result registers.
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .command_i   (command_i),
    .key_i       (key_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

`default_nettype wire
